@@ sv/rbd_pkg.sv @@
`timescale 1ns / 1ps

package rbd_pkg;

  // Fixed point format: Q.F with F fraction bits
  localparam int FRAC_BITS = 16;
  localparam int ONE       = 1 << FRAC_BITS;

  // Field widths
  localparam int T_W    = 17;
  localparam int W_W    = 18;
  localparam int CRD_W  = 32;
  localparam int DRV_W  = 48;
  localparam int COEF_W = 32;
  localparam int IN_W   = 24;
  localparam int RES_W  = 2 * CRD_W + 4 * DRV_W;

  localparam logic [T_W-1:0] T_ONE = T_W'(ONE);
  localparam logic [W_W-1:0] W_MAX = W_W'(2 * ONE);

  // Configuration register indexes
  localparam int REG_IDX_W = 3;
  localparam logic [REG_IDX_W-1:0] REG_START_X    = 3'd0;
  localparam logic [REG_IDX_W-1:0] REG_START_Y    = 3'd1;
  localparam logic [REG_IDX_W-1:0] REG_MID_X      = 3'd2;
  localparam logic [REG_IDX_W-1:0] REG_MID_Y      = 3'd3;
  localparam logic [REG_IDX_W-1:0] REG_END_X      = 3'd4;
  localparam logic [REG_IDX_W-1:0] REG_END_Y      = 3'd5;
  localparam logic [REG_IDX_W-1:0] REG_MID_WEIGHT = 3'd6;

  // Divider geometry: numerators, quotient bits, divisor (2*D) width
  localparam int DIV_LANES = 10;
  localparam int DIV_NW    = 51;
  localparam int DIV_QW    = 32;
  localparam int DIV_MW    = 19;

  // Divider lane assignment
  localparam int LANE_INV  = 0;
  localparam int LANE_FAC1 = 1;
  localparam int LANE_BN   = 2;
  localparam int LANE_BPN  = 5;
  localparam int LANE_POS  = 8;

  typedef logic signed [COEF_W-1:0] coef_t;
  typedef logic signed [63:0]       wide_t;
  typedef logic signed [DRV_W-1:0]  drv_t;
  typedef logic signed [CRD_W-1:0]  crd_t;

  typedef struct packed {
    logic                 valid;
    logic [DIV_LANES-1:0] neg;
  } div_tag_t;

  localparam wide_t DRV_HI = (64'sd1 <<< (DRV_W - 1)) - 64'sd1;
  localparam wide_t DRV_LO = -(64'sd1 <<< (DRV_W - 1));

  // x / 2^F rounded to nearest, ties away from zero
  function automatic wide_t rnd_frac(input wide_t x);
    wide_t mag;
    wide_t q;
    mag = x[63] ? -x : x;
    q   = (mag + (64'sd1 <<< (FRAC_BITS - 1))) >>> FRAC_BITS;
    return x[63] ? -q : q;
  endfunction

  function automatic drv_t sat_drv(input wide_t x);
    wide_t y;
    y = (x > DRV_HI) ? DRV_HI : ((x < DRV_LO) ? DRV_LO : x);
    return y[DRV_W-1:0];
  endfunction

endpackage

@@ sv/rbd_div.sv @@
`timescale 1ns / 1ps

// Pipelined restoring divider: one quotient bit per stage, all lanes share
// one divisor. Quotient must fit in DIV_QW bits.
module rbd_div
  import rbd_pkg::*;
(
  input  logic                               clk_i,
  input  logic                               rst_ni,
  input  logic                               en_i,
  input  div_tag_t                           tag_i,
  input  logic [DIV_MW-1:0]                  den_i,
  input  logic [DIV_LANES-1:0][DIV_NW-1:0]   num_i,
  output div_tag_t                           tag_o,
  output logic [DIV_LANES-1:0][DIV_QW-1:0]   quo_o
);

  div_tag_t                          tag_q [DIV_QW];
  logic [DIV_MW-1:0]                 den_q [DIV_QW];
  logic [DIV_LANES-1:0][DIV_MW-1:0]  rem_q [DIV_QW-1];
  logic [DIV_LANES-1:0][DIV_QW-1:0]  low_q [DIV_QW];

  for (genvar s = 0; s < DIV_QW; s++) begin : g_stage
    div_tag_t                          tag_in;
    logic [DIV_MW-1:0]                 den_in;
    logic [DIV_LANES-1:0][DIV_MW-1:0]  rem_in;
    logic [DIV_LANES-1:0][DIV_MW-1:0]  rem_d;
    logic [DIV_LANES-1:0][DIV_QW-1:0]  low_in;
    logic [DIV_LANES-1:0][DIV_QW-1:0]  low_d;
    logic [DIV_LANES-1:0][DIV_MW:0]    sh;
    logic [DIV_LANES-1:0][DIV_MW:0]    diff;
    logic [DIV_LANES-1:0]              ge;

    if (s == 0) begin : g_head
      always_comb begin
        tag_in = tag_i;
        den_in = den_i;
        for (int l = 0; l < DIV_LANES; l++) begin
          rem_in[l] = DIV_MW'(num_i[l] >> DIV_QW);
          low_in[l] = num_i[l][DIV_QW-1:0];
        end
      end
    end else begin : g_body
      assign tag_in = tag_q[s-1];
      assign den_in = den_q[s-1];
      assign rem_in = rem_q[s-1];
      assign low_in = low_q[s-1];
    end

    // Shift in the next numerator bit, subtract when it fits
    always_comb begin
      for (int l = 0; l < DIV_LANES; l++) begin
        sh[l]    = {rem_in[l], low_in[l][DIV_QW-1]};
        diff[l]  = sh[l] - {1'b0, den_in};
        ge[l]    = (sh[l] >= {1'b0, den_in});
        rem_d[l] = ge[l] ? diff[l][DIV_MW-1:0] : sh[l][DIV_MW-1:0];
        low_d[l] = {low_in[l][DIV_QW-2:0], ge[l]};
      end
    end

    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        tag_q[s] <= '0;
      end else if (en_i) begin
        tag_q[s] <= tag_in;
      end
    end

    always_ff @(posedge clk_i) begin
      if (en_i) begin
        den_q[s] <= den_in;
        low_q[s] <= low_d;
      end
    end

    if (s < DIV_QW - 1) begin : g_rem
      always_ff @(posedge clk_i) begin
        if (en_i) begin
          rem_q[s] <= rem_d;
        end
      end
    end
  end

  assign tag_o = tag_q[DIV_QW-1];
  assign quo_o = low_q[DIV_QW-1];

endmodule

@@ sv/rational_bezier_derivatives.sv @@
`timescale 1ns / 1ps

// Rational quadratic Bezier evaluator with first and second derivatives.
// Software writes the three control points and the middle weight through
// the configuration channel (cfg_valid_i/cfg_ready_o, cfg_index_i selects
// start_x, start_y, mid_x, mid_y, end_x, end_y, mid_weight in that order;
// other indexes are dropped). Write configuration only while no request is
// in flight. Each request on the s_axis side carries one Q1.16 parameter t
// and yields exactly one result on the m_axis side: point (Q16.16) and
// first and second derivatives (Q32.16, saturated).
// A new request is taken every cycle while the skid register is empty. The
// pipeline has 42 register stages, the first loaded at the accepting edge:
// 3 stages ahead of the 32-stage shared divider that forms all quotients
// by the basis sum D, 6 stages of multiply and sum after it and the output
// register.
// Reset clears all valid bits and sets the points to zero and the weight
// to one. When the receiver stalls, the output register holds its result
// and a skid register takes one more; the pipeline then freezes and
// s_axis_tready drops until the skid register drains.
module rational_bezier_derivatives
  import rbd_pkg::*;
(
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 cfg_valid_i,
  output logic                 cfg_ready_o,
  input  logic [REG_IDX_W-1:0] cfg_index_i,
  input  logic [CRD_W-1:0]     cfg_data_i,
  input  logic                 s_axis_tvalid,
  output logic                 s_axis_tready,
  input  logic [IN_W-1:0]      s_axis_tdata,  // [16:0] param_t, rest zero
  output logic                 m_axis_tvalid,
  input  logic                 m_axis_tready,
  // [31:0] pos_x, [63:32] pos_y, [111:64] slope_x, [159:112] slope_y,
  // [207:160] bend_x, [255:208] bend_y
  output logic [RES_W-1:0]     m_axis_tdata
);

  // ---------------------------------------------------------------------
  // Configuration registers: pt_q[2*i+axis], i = start, mid, end
  // ---------------------------------------------------------------------
  crd_t           pt_q [6];
  logic [W_W-1:0] weight_q;

  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < 6; i++) pt_q[i] <= '0;
      weight_q <= W_W'(ONE);
    end else if (cfg_valid_i) begin
      unique case (cfg_index_i)
        REG_START_X:    pt_q[0] <= cfg_data_i;
        REG_START_Y:    pt_q[1] <= cfg_data_i;
        REG_MID_X:      pt_q[2] <= cfg_data_i;
        REG_MID_Y:      pt_q[3] <= cfg_data_i;
        REG_END_X:      pt_q[4] <= cfg_data_i;
        REG_END_Y:      pt_q[5] <= cfg_data_i;
        REG_MID_WEIGHT: weight_q <= cfg_data_i[W_W-1:0];
        default: ;
      endcase
    end
  end

  // ---------------------------------------------------------------------
  // Global advance: the pipeline moves unless the skid register is full
  // ---------------------------------------------------------------------
  logic en;
  logic skid_valid_q;

  assign en            = !skid_valid_q;
  assign s_axis_tready = en;

  // Clamp t to one and the weight to two
  logic [T_W-1:0] t_in;
  coef_t          t_c;
  coef_t          s_c;
  coef_t          w_c;

  always_comb begin
    t_in = s_axis_tdata[T_W-1:0];
    t_c  = (t_in > T_ONE) ? coef_t'(T_ONE) : coef_t'(t_in);
    w_c  = (weight_q > W_MAX) ? coef_t'(W_MAX) : coef_t'(weight_q);
    s_c  = coef_t'(ONE) - t_c;
  end

  // ---------------------------------------------------------------------
  // Stage 1: t*s, the middle-term derivative and square terms of the basis
  // ---------------------------------------------------------------------
  logic  v1_q;
  coef_t t1_q, b0_1_q, b2_1_q, ts_1_q, bp1_1_q;

  always_ff @(posedge clk_i) begin
    if (en) begin
      t1_q    <= t_c;
      b0_1_q  <= coef_t'(rnd_frac(wide_t'(s_c) * wide_t'(s_c)));
      b2_1_q  <= coef_t'(rnd_frac(wide_t'(t_c) * wide_t'(t_c)));
      ts_1_q  <= coef_t'(rnd_frac(wide_t'(t_c) * wide_t'(s_c)));
      bp1_1_q <= coef_t'(rnd_frac(wide_t'(w_c) *
                                  wide_t'(coef_t'(ONE) - (t_c <<< 1))));
    end
  end

  // ---------------------------------------------------------------------
  // Stage 2: weighted middle term and sum of first derivatives
  // ---------------------------------------------------------------------
  logic  v2_q;
  coef_t t2_q, b0_2_q, b1_2_q, b2_2_q, bp1_2_q, wp_2_q;

  always_ff @(posedge clk_i) begin
    if (en) begin
      t2_q    <= t1_q;
      b0_2_q  <= b0_1_q;
      b2_2_q  <= b2_1_q;
      bp1_2_q <= bp1_1_q;
      b1_2_q  <= coef_t'(rnd_frac(wide_t'(w_c) * wide_t'(ts_1_q)));
      wp_2_q  <= bp1_1_q + (t1_q <<< 2) - (coef_t'(ONE) <<< 1);
    end
  end

  // ---------------------------------------------------------------------
  // Stage 3: basis sum D, end-point derivative terms and point products
  // ---------------------------------------------------------------------
  logic              v3_q;
  logic [DIV_MW-2:0] d3_q;
  coef_t             b_3_q  [3];
  coef_t             bp_3_q [3];
  coef_t             wp_3_q;
  wide_t             prod3_q [2][3];
  coef_t             b_2    [3];
  coef_t             d_2;

  always_comb begin
    b_2[0] = b0_2_q;
    b_2[1] = b1_2_q;
    b_2[2] = b2_2_q;
    d_2    = b0_2_q + b1_2_q + b2_2_q;
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      d3_q      <= d_2[DIV_MW-2:0];
      wp_3_q    <= wp_2_q;
      bp_3_q[0] <= (t2_q <<< 1) - (coef_t'(ONE) <<< 1);
      bp_3_q[1] <= bp1_2_q;
      bp_3_q[2] <= t2_q <<< 1;
      for (int i = 0; i < 3; i++) begin
        b_3_q[i] <= b_2[i];
        for (int ax = 0; ax < 2; ax++) begin
          prod3_q[ax][i] <= wide_t'(b_2[i]) * wide_t'(pt_q[2*i+ax]);
        end
      end
    end
  end

  // ---------------------------------------------------------------------
  // Divider feed: every quotient by D as floor((2|n| + D) / 2D)
  // ---------------------------------------------------------------------
  wide_t                            lane_n   [DIV_LANES];
  wide_t                            lane_mag [DIV_LANES];
  logic [DIV_LANES-1:0][DIV_NW-1:0] div_num;
  div_tag_t                         div_tag_in;
  div_tag_t                         div_tag_out;
  logic [DIV_LANES-1:0][DIV_QW-1:0] div_quo;

  always_comb begin
    lane_n[LANE_INV]  = wide_t'(64'sd1 <<< (2 * FRAC_BITS));
    lane_n[LANE_FAC1] = wide_t'(wp_3_q) <<< FRAC_BITS;
    for (int i = 0; i < 3; i++) begin
      lane_n[LANE_BN+i]  = wide_t'(b_3_q[i]) <<< FRAC_BITS;
      lane_n[LANE_BPN+i] = wide_t'(bp_3_q[i]) <<< FRAC_BITS;
    end
    for (int ax = 0; ax < 2; ax++) begin
      lane_n[LANE_POS+ax] = prod3_q[ax][0] + prod3_q[ax][1] + prod3_q[ax][2];
    end
    div_tag_in.valid = v3_q;
    for (int l = 0; l < DIV_LANES; l++) begin
      div_tag_in.neg[l] = lane_n[l][63];
      lane_mag[l]       = lane_n[l][63] ? -lane_n[l] : lane_n[l];
      div_num[l]        = DIV_NW'((lane_mag[l] <<< 1) + wide_t'(d3_q));
    end
  end

  rbd_div u_div (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .en_i   (en),
    .tag_i  (div_tag_in),
    .den_i  ({d3_q, 1'b0}),
    .num_i  (div_num),
    .tag_o  (div_tag_out),
    .quo_o  (div_quo)
  );

  // ---------------------------------------------------------------------
  // A1: restore signs, clamp the point
  // ---------------------------------------------------------------------
  localparam logic signed [CRD_W+1:0] POS_HI = (34'sd1 <<< (CRD_W - 1)) - 34'sd1;
  localparam logic signed [CRD_W+1:0] POS_LO = -(34'sd1 <<< (CRD_W - 1));

  logic                     a1_v_q;
  coef_t                    inv_1_q, fac1_1_q;
  coef_t                    bn_1_q  [3];
  coef_t                    bpn_1_q [3];
  crd_t                     pos_1_q [2];
  coef_t                    sq      [DIV_LANES];
  logic signed [CRD_W+1:0]  pq      [2];

  always_comb begin
    for (int l = 0; l < DIV_LANES; l++) begin
      sq[l] = coef_t'(div_tag_out.neg[l] ? -div_quo[l] : div_quo[l]);
    end
    for (int ax = 0; ax < 2; ax++) begin
      pq[ax] = div_tag_out.neg[LANE_POS+ax] ? -$signed({2'b00, div_quo[LANE_POS+ax]})
                                            : $signed({2'b00, div_quo[LANE_POS+ax]});
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      inv_1_q  <= sq[LANE_INV];
      fac1_1_q <= sq[LANE_FAC1];
      for (int i = 0; i < 3; i++) begin
        bn_1_q[i]  <= sq[LANE_BN+i];
        bpn_1_q[i] <= sq[LANE_BPN+i];
      end
      for (int ax = 0; ax < 2; ax++) begin
        pos_1_q[ax] <= (pq[ax] > POS_HI) ? POS_HI[CRD_W-1:0] :
                       ((pq[ax] < POS_LO) ? POS_LO[CRD_W-1:0] : pq[ax][CRD_W-1:0]);
      end
    end
  end

  // ---------------------------------------------------------------------
  // A2: products with 1/D and the first log-derivative factor
  // ---------------------------------------------------------------------
  coef_t wpp_c;
  coef_t bpp_c [3];

  always_comb begin
    wpp_c    = (coef_t'(ONE) <<< 2) - (w_c <<< 1);
    bpp_c[0] = coef_t'(ONE) <<< 1;
    bpp_c[1] = -(w_c <<< 1);
    bpp_c[2] = coef_t'(ONE) <<< 1;
  end

  logic  a2_v_q;
  coef_t m_wi_2_q, m_ff_2_q;
  coef_t m_bf_2_q [3];
  coef_t m_pi_2_q [3];
  coef_t m_qf_2_q [3];
  coef_t bn_2_q   [3];
  coef_t bpn_2_q  [3];
  crd_t  pos_2_q  [2];

  always_ff @(posedge clk_i) begin
    if (en) begin
      m_wi_2_q <= coef_t'(rnd_frac(wide_t'(wpp_c) * wide_t'(inv_1_q)));
      m_ff_2_q <= coef_t'(rnd_frac(wide_t'(fac1_1_q) * wide_t'(fac1_1_q)));
      for (int i = 0; i < 3; i++) begin
        m_bf_2_q[i] <= coef_t'(rnd_frac(wide_t'(bn_1_q[i]) * wide_t'(fac1_1_q)));
        m_pi_2_q[i] <= coef_t'(rnd_frac(wide_t'(bpp_c[i]) * wide_t'(inv_1_q)));
        m_qf_2_q[i] <= coef_t'(rnd_frac(wide_t'(bpn_1_q[i]) * wide_t'(fac1_1_q)));
        bn_2_q[i]   <= bn_1_q[i];
        bpn_2_q[i]  <= bpn_1_q[i];
      end
      pos_2_q <= pos_1_q;
    end
  end

  // ---------------------------------------------------------------------
  // A3: second factor, first-derivative coefficients, partial k
  // ---------------------------------------------------------------------
  logic  a3_v_q;
  coef_t fac2_3_q;
  coef_t c_3_q  [3];
  coef_t k0_3_q [3];
  coef_t bn_3_q [3];
  crd_t  pos_3_q [2];

  always_ff @(posedge clk_i) begin
    if (en) begin
      fac2_3_q <= m_wi_2_q - (m_ff_2_q <<< 1);
      for (int i = 0; i < 3; i++) begin
        c_3_q[i]  <= bpn_2_q[i] - m_bf_2_q[i];
        k0_3_q[i] <= m_pi_2_q[i] - (m_qf_2_q[i] <<< 1);
        bn_3_q[i] <= bn_2_q[i];
      end
      pos_3_q <= pos_2_q;
    end
  end

  // ---------------------------------------------------------------------
  // A4: second-derivative coefficients
  // ---------------------------------------------------------------------
  logic  a4_v_q;
  coef_t c_4_q [3];
  coef_t k_4_q [3];
  crd_t  pos_4_q [2];

  always_ff @(posedge clk_i) begin
    if (en) begin
      for (int i = 0; i < 3; i++) begin
        c_4_q[i] <= c_3_q[i];
        k_4_q[i] <= k0_3_q[i] -
                    coef_t'(rnd_frac(wide_t'(bn_3_q[i]) * wide_t'(fac2_3_q)));
      end
      pos_4_q <= pos_3_q;
    end
  end

  // ---------------------------------------------------------------------
  // A5: coefficient times point, split into integer and fraction parts
  // ---------------------------------------------------------------------
  logic  a5_v_q;
  wide_t pch_5_q [2][3];
  wide_t pcl_5_q [2][3];
  wide_t pkh_5_q [2][3];
  wide_t pkl_5_q [2][3];
  crd_t  pos_5_q [2];
  coef_t ch_c [3];
  coef_t cl_c [3];
  coef_t kh_c [3];
  coef_t kl_c [3];

  always_comb begin
    for (int i = 0; i < 3; i++) begin
      ch_c[i] = c_4_q[i] >>> FRAC_BITS;
      cl_c[i] = coef_t'({{(COEF_W-FRAC_BITS){1'b0}}, c_4_q[i][FRAC_BITS-1:0]});
      kh_c[i] = k_4_q[i] >>> FRAC_BITS;
      kl_c[i] = coef_t'({{(COEF_W-FRAC_BITS){1'b0}}, k_4_q[i][FRAC_BITS-1:0]});
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      for (int ax = 0; ax < 2; ax++) begin
        for (int i = 0; i < 3; i++) begin
          pch_5_q[ax][i] <= wide_t'(pt_q[2*i+ax]) * wide_t'(ch_c[i]);
          pcl_5_q[ax][i] <= wide_t'(pt_q[2*i+ax]) * wide_t'(cl_c[i]);
          pkh_5_q[ax][i] <= wide_t'(pt_q[2*i+ax]) * wide_t'(kh_c[i]);
          pkl_5_q[ax][i] <= wide_t'(pt_q[2*i+ax]) * wide_t'(kl_c[i]);
        end
      end
      pos_5_q <= pos_4_q;
    end
  end

  // ---------------------------------------------------------------------
  // A6: sum the terms and saturate the derivatives
  // ---------------------------------------------------------------------
  logic  a6_v_q;
  drv_t  slope_6_q [2];
  drv_t  bend_6_q  [2];
  crd_t  pos_6_q   [2];
  wide_t d1_c [2];
  wide_t d2_c [2];

  always_comb begin
    for (int ax = 0; ax < 2; ax++) begin
      d1_c[ax] = '0;
      d2_c[ax] = '0;
      for (int i = 0; i < 3; i++) begin
        d1_c[ax] = d1_c[ax] + pch_5_q[ax][i] + rnd_frac(pcl_5_q[ax][i]);
        d2_c[ax] = d2_c[ax] + pkh_5_q[ax][i] + rnd_frac(pkl_5_q[ax][i]);
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      for (int ax = 0; ax < 2; ax++) begin
        slope_6_q[ax] <= sat_drv(d1_c[ax]);
        bend_6_q[ax]  <= sat_drv(d2_c[ax]);
      end
      pos_6_q <= pos_5_q;
    end
  end

  // Valid bits travel with the data
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q   <= 1'b0;
      v2_q   <= 1'b0;
      v3_q   <= 1'b0;
      a1_v_q <= 1'b0;
      a2_v_q <= 1'b0;
      a3_v_q <= 1'b0;
      a4_v_q <= 1'b0;
      a5_v_q <= 1'b0;
      a6_v_q <= 1'b0;
    end else if (en) begin
      v1_q   <= s_axis_tvalid;
      v2_q   <= v1_q;
      v3_q   <= v2_q;
      a1_v_q <= div_tag_out.valid;
      a2_v_q <= a1_v_q;
      a3_v_q <= a2_v_q;
      a4_v_q <= a3_v_q;
      a5_v_q <= a4_v_q;
      a6_v_q <= a5_v_q;
    end
  end

  // ---------------------------------------------------------------------
  // Output register with skid register
  // ---------------------------------------------------------------------
  logic [RES_W-1:0] res_c;
  logic [RES_W-1:0] out_q, skid_q;
  logic             out_valid_q, out_valid_d, skid_valid_d;
  logic             take, load;

  assign res_c = {bend_6_q[1], bend_6_q[0], slope_6_q[1], slope_6_q[0],
                  pos_6_q[1], pos_6_q[0]};
  assign take  = out_valid_q && m_axis_tready;
  assign load  = en && a6_v_q;

  always_comb begin
    out_valid_d  = out_valid_q;
    skid_valid_d = skid_valid_q;
    if (!out_valid_q || take) begin
      // Refill from the skid register first, else from the pipeline
      out_valid_d  = skid_valid_q || load;
      skid_valid_d = 1'b0;
    end else if (load) begin
      skid_valid_d = 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q  <= 1'b0;
      skid_valid_q <= 1'b0;
    end else begin
      out_valid_q  <= out_valid_d;
      skid_valid_q <= skid_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (!out_valid_q || take) begin
      out_q <= skid_valid_q ? skid_q : res_c;
    end else if (load) begin
      skid_q <= res_c;
    end
  end

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = out_q;

endmodule

@@ sv/rbd_checker.sv @@
`timescale 1ns / 1ps

module rbd_checker
  import rbd_pkg::*;
(
  input logic             clk_i,
  input logic             rst_ni,
  input logic             s_axis_tready,
  input logic             m_axis_tvalid,
  input logic             m_axis_tready,
  input logic [RES_W-1:0] m_axis_tdata
);

  // Hold a stalled result
  a_valid_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid)
    else $error("result dropped while stalled");

  a_data_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && !m_axis_tready |=> $stable(m_axis_tdata))
    else $error("result changed while stalled");

  // Backpressure only while a result waits at the output
  a_ready_cause: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !s_axis_tready |-> m_axis_tvalid)
    else $error("input stalled with no pending result");

  // Nothing comes out right after reset
  a_reset_empty: assert property (@(posedge clk_i)
    !rst_ni |=> !m_axis_tvalid)
    else $error("result present after reset");

  // Once the receiver takes the held result, the input opens again
  a_ready_recover: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !s_axis_tready && m_axis_tready |=> s_axis_tready)
    else $error("input stayed stalled after the output drained");

endmodule

bind rational_bezier_derivatives rbd_checker u_rbd_checker (
  .clk_i         (clk_i),
  .rst_ni        (rst_ni),
  .s_axis_tready (s_axis_tready),
  .m_axis_tvalid (m_axis_tvalid),
  .m_axis_tready (m_axis_tready),
  .m_axis_tdata  (m_axis_tdata)
);

@@ bench/rational_bezier_derivatives_tb.sv @@
`timescale 1ns / 1ps

module rational_bezier_derivatives_tb;
  import rbd_pkg::*;

  // Index 7 decodes to no register; the block must drop writes to it
  localparam logic [REG_IDX_W-1:0] REG_NONE = 3'd7;
  localparam longint Q_ONE    = longint'(ONE);
  localparam int     SETTLE   = 60;    // cycles to cover the pipeline latency
  localparam int     WD_LIMIT = 3000;  // cycles with no request moving
  localparam int     HOLD_LEN = 400;   // long receiver hold-off

  logic                 clk_i = 1'b0;
  logic                 rst_ni = 1'b0;
  logic                 cfg_valid_i = 1'b0;
  logic                 cfg_ready_o;
  logic [REG_IDX_W-1:0] cfg_index_i = '0;
  logic [CRD_W-1:0]     cfg_data_i = '0;
  logic                 s_axis_tvalid = 1'b0;
  logic                 s_axis_tready;
  logic [IN_W-1:0]      s_axis_tdata = '0;
  logic                 m_axis_tvalid;
  logic                 m_axis_tready = 1'b0;
  logic [RES_W-1:0]     m_axis_tdata;

  rational_bezier_derivatives dut (.*);

  always #6 clk_i = ~clk_i;

  // Shadow of the configuration registers
  logic signed [CRD_W-1:0] ctrl_pt[6];
  logic [W_W-1:0]          weight_reg;

  logic [RES_W-1:0] curve_q[$];
  int               error_cnt = 0;
  int               tx_idle_pct = 0;
  int               rx_idle_pct = 0;
  logic             rx_holding = 1'b0;
  event             start_hold;

  // n/d rounded to nearest, ties away from zero
  function automatic longint round_div(longint n, longint d);
    longint unsigned m, q;
    if (d <= 0) return 0;
    m = (n < 0) ? longint'(-n) : n;
    q = (2 * m + longint'(d)) / (2 * longint'(d));
    return (n < 0) ? -longint'(q) : longint'(q);
  endfunction

  // round(k * p / one), with k split into integer and fraction parts
  function automatic longint scale_coord(longint k, longint p);
    longint kh, kl;
    kh = k / Q_ONE;
    kl = k - kh * Q_ONE;
    if (kl < 0) begin
      kl += Q_ONE;
      kh -= 1;
    end
    return p * kh + round_div(p * kl, Q_ONE);
  endfunction

  function automatic longint clip(longint v, longint lo, longint hi);
    return (v < lo) ? lo : ((v > hi) ? hi : v);
  endfunction

  // Curve point plus first and second derivative for one parameter
  function automatic logic [RES_W-1:0] eval_curve(input logic [T_W-1:0] t_in);
    longint tt, ww, ss, dsum, dw1, dw2, inv_d, fac1, fac2, num, pos, d1, d2;
    longint b[3], bp[3], bpp[3], bn[3], bpn[3], c[3], k[3], p[3];
    logic [CRD_W-1:0] pos_v[2];
    logic [DRV_W-1:0] slope_v[2], bend_v[2];
    tt = t_in;
    if (tt > Q_ONE) tt = Q_ONE;          // clamp t to one
    ww = weight_reg;
    if (ww > 2 * Q_ONE) ww = 2 * Q_ONE;  // clamp weight to two
    ss = Q_ONE - tt;
    b[0] = round_div(ss * ss, Q_ONE);
    b[1] = round_div(ww * round_div(tt * ss, Q_ONE), Q_ONE);
    b[2] = round_div(tt * tt, Q_ONE);
    dsum = b[0] + b[1] + b[2];
    bp[0] = 2 * (tt - Q_ONE);
    bp[1] = round_div(ww * (Q_ONE - 2 * tt), Q_ONE);
    bp[2] = 2 * tt;
    dw1 = bp[0] + bp[1] + bp[2];
    bpp[0] = 2 * Q_ONE;
    bpp[1] = -2 * ww;
    bpp[2] = 2 * Q_ONE;
    dw2 = bpp[0] + bpp[1] + bpp[2];
    inv_d = round_div(Q_ONE * Q_ONE, dsum);
    fac1 = round_div(dw1 * Q_ONE, dsum);
    fac2 = round_div(dw2 * inv_d, Q_ONE) - 2 * round_div(fac1 * fac1, Q_ONE);
    for (int i = 0; i < 3; i++) begin
      bn[i]  = round_div(b[i] * Q_ONE, dsum);
      bpn[i] = round_div(bp[i] * Q_ONE, dsum);
      c[i]   = bpn[i] - round_div(bn[i] * fac1, Q_ONE);
      k[i]   = round_div(bpp[i] * inv_d, Q_ONE) - 2 * round_div(bpn[i] * fac1, Q_ONE)
               - round_div(bn[i] * fac2, Q_ONE);
    end
    for (int ax = 0; ax < 2; ax++) begin
      num = 0;
      d1 = 0;
      d2 = 0;
      for (int i = 0; i < 3; i++) begin
        p[i] = longint'(ctrl_pt[2 * i + ax]);
        num += b[i] * p[i];
        d1  += scale_coord(c[i], p[i]);
        d2  += scale_coord(k[i], p[i]);
      end
      pos = clip(round_div(num, dsum), -64'sd2147483648, 64'sd2147483647);
      d1  = clip(d1, DRV_LO, DRV_HI);
      d2  = clip(d2, DRV_LO, DRV_HI);
      pos_v[ax]   = pos[CRD_W-1:0];
      slope_v[ax] = d1[DRV_W-1:0];
      bend_v[ax]  = d2[DRV_W-1:0];
    end
    return {bend_v[1], bend_v[0], slope_v[1], slope_v[0], pos_v[1], pos_v[0]};
  endfunction

  task automatic report_mismatch(string field, longint got, longint want);
    $display("mismatch %s: got %0d expected %0d", field, got, want);
    error_cnt++;
  endtask

  // Check each result against the oldest prediction; drive receiver stalls
  always @(posedge clk_i) begin
    logic [RES_W-1:0] want;
    if (m_axis_tvalid && m_axis_tready) begin
      if (curve_q.size() == 0) begin
        // one result seen where none was outstanding
        report_mismatch("outstanding results", 1, 0);
      end else begin
        want = curve_q.pop_front();
        if (m_axis_tdata[31:0] !== want[31:0])
          report_mismatch("pos_x", crd_t'(m_axis_tdata[31:0]), crd_t'(want[31:0]));
        if (m_axis_tdata[63:32] !== want[63:32])
          report_mismatch("pos_y", crd_t'(m_axis_tdata[63:32]), crd_t'(want[63:32]));
        if (m_axis_tdata[111:64] !== want[111:64])
          report_mismatch("slope_x", drv_t'(m_axis_tdata[111:64]), drv_t'(want[111:64]));
        if (m_axis_tdata[159:112] !== want[159:112])
          report_mismatch("slope_y", drv_t'(m_axis_tdata[159:112]),
                          drv_t'(want[159:112]));
        if (m_axis_tdata[207:160] !== want[207:160])
          report_mismatch("bend_x", drv_t'(m_axis_tdata[207:160]), drv_t'(want[207:160]));
        if (m_axis_tdata[255:208] !== want[255:208])
          report_mismatch("bend_y", drv_t'(m_axis_tdata[255:208]), drv_t'(want[255:208]));
      end
    end
    if (!rst_ni || rx_holding)
      m_axis_tready <= 1'b0;
    else
      m_axis_tready <= ($urandom_range(99, 0) >= rx_idle_pct);
  end

  // Long receiver hold-off, counted here so the sender keeps going
  always begin
    @(start_hold);
    @(posedge clk_i);
    rx_holding <= 1'b1;
    repeat (HOLD_LEN) @(posedge clk_i);
    rx_holding <= 1'b0;
  end

  // Watchdog: end the run if nothing moves for too long
  always @(posedge clk_i) begin
    int stuck;
    if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready) ||
        (cfg_valid_i && cfg_ready_o))
      stuck = 0;
    else
      stuck++;
    if (stuck >= WD_LIMIT) begin
      $display("watchdog: no progress for %0d cycles", stuck);
      $display("rational_bezier_derivatives_tb: errors");
      $finish;
    end
  end

  // Offer one parameter; predict its result when the request is taken
  task automatic send_param(input logic [T_W-1:0] t);
    if (tx_idle_pct > 0 && $urandom_range(99, 0) < tx_idle_pct) begin
      s_axis_tvalid <= 1'b0;
      do @(posedge clk_i); while ($urandom_range(99, 0) < tx_idle_pct);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= {{(IN_W - T_W){1'b0}}, t};
    do @(posedge clk_i); while (!s_axis_tready);
    curve_q.push_back(eval_curve(t));
  endtask

  // Drop valid, wait for every outstanding result, then let the pipe settle
  task automatic wait_drain();
    s_axis_tvalid <= 1'b0;
    while (curve_q.size() != 0) @(posedge clk_i);
    repeat (SETTLE) @(posedge clk_i);
  endtask

  task automatic write_reg(input logic [REG_IDX_W-1:0] idx, input logic [CRD_W-1:0] val);
    wait_drain();
    cfg_valid_i <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i  <= val;
    do @(posedge clk_i); while (!cfg_ready_o);
    cfg_valid_i <= 1'b0;
    if (idx == REG_MID_WEIGHT) weight_reg = val[W_W-1:0];
    else if (idx != REG_NONE) ctrl_pt[idx] = val;
  endtask

  task automatic load_curve(input logic [CRD_W-1:0] sx, sy, mx, my, ex, ey,
                            input logic [W_W-1:0] w);
    write_reg(REG_START_X, sx);
    write_reg(REG_START_Y, sy);
    write_reg(REG_MID_X, mx);
    write_reg(REG_MID_Y, my);
    write_reg(REG_END_X, ex);
    write_reg(REG_END_Y, ey);
    write_reg(REG_MID_WEIGHT, {{(CRD_W - W_W){1'b0}}, w});
  endtask

  function automatic logic [CRD_W-1:0] rand_coord();
    case ($urandom_range(5, 0))
      0:       return 32'h7FFF_FFFF;
      1:       return 32'h8000_0000;
      2:       return $urandom_range(32'h0040_0000, 0) - 32'h0020_0000;
      default: return $urandom();
    endcase
  endfunction

  function automatic logic [W_W-1:0] rand_weight();
    case ($urandom_range(5, 0))
      0:       return '0;
      1:       return W_MAX;
      2:       return W_W'($urandom());  // may exceed two, so it clamps
      default: return W_W'($urandom_range(W_MAX, 0));
    endcase
  endfunction

  function automatic logic [T_W-1:0] rand_param();
    // mostly in [0,1], sometimes anything the field holds
    if ($urandom_range(9, 0) == 0) return T_W'($urandom());
    return T_W'($urandom_range(ONE, 0));
  endfunction

  // Corner parameters and weights, including t and weight above their clamps
  task automatic test_directed();
    logic [T_W-1:0] corner_t[6] = '{17'd0, 17'd1, 17'd32768, 17'h10000, 17'h10001, 17'h1FFFF};
    load_curve(32'h0001_0000, 32'hFFFE_0000, 32'h0005_8000, 32'h0003_0000,
               32'hFFFA_0000, 32'h0000_4000, W_W'(ONE));
    foreach (corner_t[i]) send_param(corner_t[i]);
    write_reg(REG_MID_WEIGHT, 32'd0);
    foreach (corner_t[i]) send_param(corner_t[i]);
    write_reg(REG_MID_WEIGHT, 32'h0003_FFFF);
    foreach (corner_t[i]) send_param(corner_t[i]);
    // extreme points give derivatives of large magnitude
    load_curve(32'h7FFF_FFFF, 32'h8000_0000, 32'h8000_0000, 32'h7FFF_FFFF,
               32'h7FFF_FFFF, 32'h8000_0000, W_MAX);
    foreach (corner_t[i]) send_param(corner_t[i]);
  endtask

  // A write to an unused index must leave every register alone
  task automatic test_unused_index();
    write_reg(REG_NONE, 32'hDEAD_BEEF);
    send_param(17'd12345);
    send_param(17'd50000);
  endtask

  task automatic test_random(input int tx_pct, input int rx_pct);
    tx_idle_pct = tx_pct;
    rx_idle_pct = rx_pct;
    for (int cfg = 0; cfg < 5; cfg++) begin
      load_curve(rand_coord(), rand_coord(), rand_coord(), rand_coord(),
                 rand_coord(), rand_coord(), rand_weight());
      repeat (100) send_param(rand_param());
    end
  endtask

  // Stall the receiver long enough that the block fills and stops accepting
  task automatic test_backpressure();
    tx_idle_pct = 0;
    rx_idle_pct = 0;
    wait_drain();
    -> start_hold;
    repeat (120) send_param(rand_param());
  endtask

  // Sender pauses until the pipe is empty, then resumes
  task automatic test_pause();
    repeat (20) send_param(rand_param());
    wait_drain();
    repeat (20) send_param(rand_param());
  endtask

  initial begin
    foreach (ctrl_pt[i]) ctrl_pt[i] = '0;
    weight_reg = W_W'(ONE);
    repeat (9) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    test_directed();
    test_unused_index();
    test_random(31, 69);
    test_random(69, 31);
    test_random(0, 0);
    test_backpressure();
    test_pause();
    wait_drain();
    if (error_cnt == 0)
      $display("rational_bezier_derivatives_tb: clean");
    else
      $display("rational_bezier_derivatives_tb: errors");
    $finish;
  end

endmodule
